@@ sv/fbik_pkg.sv @@
// Shared widths, constants and types of the five-bar leg IK block.
// Used by every module under sv/; depends on nothing.
package fbik_pkg;

  localparam int POS_FRAC_BITS   = 4;
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int ZQ              = 29;

  localparam int IN_W   = 14;
  localparam int LEN_W  = 13;
  localparam int OUT_W  = 16;
  localparam int W1     = 32;   // linear terms and polynomial sums
  localparam int DISC_W = 60;   // discriminants and squares
  localparam int ROOT_W = 30;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int NUM_W  = 32;   // atan numerator and denominator
  localparam int XY_W   = 37;   // rotator x/y
  localparam int MAG_W  = 34;
  localparam int NORM_TOP   = 33;  // normalized magnitude lands in [2^32, 2^33)
  localparam int NORM_STEPS = 6;   // shifts of 32,16,8,4,2,1
  localparam int CORDIC_STEPS = 30;
  localparam int Z_W    = 32;
  localparam int ANG_W  = 34;
  localparam int SEL_W  = 36;

  localparam int CORDIC_LAT = 1 + NORM_STEPS + CORDIC_STEPS + 1;
  localparam int LEG_LAT    = 5 + SQRT_STEPS + 1 + CORDIC_LAT + 2;

  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 72;
  localparam int CFG_IDX_W   = 3;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1600);

  localparam logic signed [SEL_W-1:0] PI_Z         = SEL_W'(64'd1686629713);
  localparam logic signed [SEL_W-1:0] HALF_PI_Z    = SEL_W'(64'd843314856);
  localparam logic signed [SEL_W-1:0] QUARTER_PI_Z = SEL_W'(64'd421657428);
  localparam logic signed [ANG_W-1:0] TWO_HALF_PI  = ANG_W'(64'd1686629712);

  localparam logic signed [DISC_W-1:0] DISC_TOL =
    DISC_W'((64'd1 << (4 * POS_FRAC_BITS)) / 64'd1000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINK_ONE   = 3'd0,
    REG_LINK_TWO   = 3'd1,
    REG_LINK_THREE = 3'd2,
    REG_LINK_FOUR  = 3'd3,
    REG_HIP        = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [LEN_W-1:0] l1;
    logic [LEN_W-1:0] l2;
    logic [LEN_W-1:0] l3;
    logic [LEN_W-1:0] l4;
    logic [LEN_W-1:0] l5;
  } links_t;

  // atan(2^-i) in Q29
  function automatic logic signed [Z_W-1:0] atan_step(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0: v = Z_W'(421657428);
      1: v = Z_W'(248918915);
      2: v = Z_W'(131521918);
      3: v = Z_W'(66762579);
      4: v = Z_W'(33510843);
      5: v = Z_W'(16771758);
      6: v = Z_W'(8387925);
      7: v = Z_W'(4194219);
      8: v = Z_W'(2097141);
      9: v = Z_W'(1048575);
      default: v = Z_W'(64'd1 << (ZQ - i));
    endcase
    return v;
  endfunction

endpackage

@@ sv/fbik_sqrt.sv @@
// Pipelined integer square root, one root bit per stage (floor result).
// Depends on fbik_pkg.
module fbik_sqrt (
  input  logic                      clk,
  input  logic                      en,
  input  logic [fbik_pkg::DISC_W-1:0] val,
  output logic [fbik_pkg::ROOT_W-1:0] root
);

  localparam int STEPS = fbik_pkg::SQRT_STEPS;
  localparam int DW    = fbik_pkg::DISC_W;
  localparam int RW    = fbik_pkg::ROOT_W;

  logic [DW-1:0] rem_r  [0:STEPS-2];
  logic [RW-1:0] root_r [0:STEPS-1];

  for (genvar j = 0; j < STEPS; j++) begin : g_step
    localparam int K = STEPS - 1 - j;
    logic [DW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [DW:0]   trial;
    logic          take;

    if (j == 0) begin : g_first
      assign rem_in  = val;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
    end

    // (root + 2^K)^2 - root^2; root only has bits above K
    assign trial = ((DW+1)'(root_in) << (K + 1)) | ((DW+1)'(1) << (2 * K));
    assign take  = ({1'b0, rem_in} >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[j] <= take ? (root_in | (RW'(1) << K)) : root_in;
      end
    end

    if (j < STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= take ? DW'({1'b0, rem_in} - trial) : rem_in;
        end
      end
    end
  end

  assign root = root_r[STEPS-1];

endmodule

@@ sv/fbik_cordic.sv @@
// 2*atan(num/den) in Q29: sign fold, binary normalizer, vectoring rotator.
// Depends on fbik_pkg.
module fbik_cordic (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [fbik_pkg::NUM_W-1:0] num,
  input  logic signed [fbik_pkg::NUM_W-1:0] den,
  output logic signed [fbik_pkg::ANG_W-1:0] ang
);

  localparam int XW = fbik_pkg::XY_W;
  localparam int MW = fbik_pkg::MAG_W;
  localparam int NS = fbik_pkg::NORM_STEPS;
  localparam int CS = fbik_pkg::CORDIC_STEPS;
  localparam int ZW = fbik_pkg::Z_W;
  localparam int AW = fbik_pkg::ANG_W;
  localparam int FL = NS + CS + 1;

  typedef struct packed {
    logic zero_num;
    logic zero_den;
    logic num_pos;
  } flag_t;

  logic signed [XW-1:0] x_c, y_c, ya_c;
  logic [MW-1:0]        m_c;

  always_comb begin
    x_c  = (den < 0) ? -XW'(den) : XW'(den);
    y_c  = (den < 0) ? -XW'(num) : XW'(num);
    ya_c = (y_c < 0) ? -y_c : y_c;
    m_c  = (ya_c > x_c) ? MW'(ya_c) : MW'(x_c);
  end

  logic signed [XW-1:0] nx_r [0:NS];
  logic signed [XW-1:0] ny_r [0:NS];
  logic [MW-1:0]        nm_r [0:NS];
  flag_t                fl_r [0:FL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r[0] <= x_c;
      ny_r[0] <= y_c;
      nm_r[0] <= m_c;
      fl_r[0] <= '{zero_num: (num == 0), zero_den: (den == 0), num_pos: (num > 0)};
      for (int k = 1; k < FL; k++) fl_r[k] <= fl_r[k-1];
    end
  end

  // greedy shifts keep the magnitude below 2^33
  for (genvar k = 0; k < NS; k++) begin : g_norm
    localparam int SH = 32 >> k;
    logic fits;
    assign fits = ((nm_r[k] >> (fbik_pkg::NORM_TOP - SH)) == '0);
    always_ff @(posedge clk) begin
      if (en) begin
        nm_r[k+1] <= fits ? (nm_r[k] << SH) : nm_r[k];
        nx_r[k+1] <= fits ? (nx_r[k] <<< SH) : nx_r[k];
        ny_r[k+1] <= fits ? (ny_r[k] <<< SH) : ny_r[k];
      end
    end
  end

  logic signed [XW-1:0] cx_r [0:CS-2];
  logic signed [XW-1:0] cy_r [0:CS-2];
  logic signed [ZW-1:0] cz_r [0:CS-1];

  for (genvar i = 0; i < CS; i++) begin : g_iter
    logic signed [XW-1:0] xi, yi;
    logic signed [ZW-1:0] zi;
    if (i == 0) begin : g_first
      assign xi = nx_r[NS];
      assign yi = ny_r[NS];
      assign zi = '0;
    end else begin : g_next
      assign xi = cx_r[i-1];
      assign yi = cy_r[i-1];
      assign zi = cz_r[i-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        cz_r[i] <= (yi >= 0) ? zi + fbik_pkg::atan_step(i) : zi - fbik_pkg::atan_step(i);
      end
    end

    if (i < CS - 1) begin : g_xy
      always_ff @(posedge clk) begin
        if (en) begin
          if (yi >= 0) begin
            cx_r[i] <= xi + (yi >>> i);
            cy_r[i] <= yi - (xi >>> i);
          end else begin
            cx_r[i] <= xi - (yi >>> i);
            cy_r[i] <= yi + (xi >>> i);
          end
        end
      end
    end
  end

  logic signed [AW-1:0] ang_r;
  flag_t                fo;
  assign fo = fl_r[FL-1];

  always_ff @(posedge clk) begin
    if (en) begin
      if (fo.zero_num) begin
        ang_r <= '0;
      end else if (fo.zero_den) begin
        ang_r <= fo.num_pos ? fbik_pkg::TWO_HALF_PI : -fbik_pkg::TWO_HALF_PI;
      end else begin
        ang_r <= AW'(cz_r[CS-1]) <<< 1;
      end
    end
  end

  assign ang = ang_r;

endmodule

@@ sv/fbik_leg.sv @@
// One leg lane: polynomial terms, two square roots, four atan units,
// branch selection and motor scaling. Depends on fbik_pkg, fbik_sqrt, fbik_cordic.
module fbik_leg (
  input  logic                              clk,
  input  logic                              en,
  input  fbik_pkg::links_t                  lk,
  input  logic signed [fbik_pkg::IN_W-1:0]  x,
  input  logic signed [fbik_pkg::IN_W-1:0]  y,
  output logic signed [fbik_pkg::OUT_W-1:0] alpha,
  output logic signed [fbik_pkg::OUT_W-1:0] beta,
  output logic                              reach
);

  localparam int W  = fbik_pkg::W1;
  localparam int DW = fbik_pkg::DISC_W;
  localparam int SW = fbik_pkg::SEL_W;
  localparam int SQ = fbik_pkg::SQRT_STEPS;
  localparam int CL = fbik_pkg::CORDIC_LAT;
  localparam int RND_SH = fbik_pkg::ZQ - fbik_pkg::ANGLE_FRAC_BITS;
  localparam logic signed [SW-1:0] MOTOR_OFS =
    (SW'(1) <<< (RND_SH - 1)) - fbik_pkg::HALF_PI_Z;
  localparam logic signed [SW-1:0] SAT_HI = SW'(32767);
  localparam logic signed [SW-1:0] SAT_LO = -SW'(32768);

  function automatic logic signed [2*W-1:0] sq(input logic signed [W-1:0] v);
    sq = v * v;
  endfunction

  typedef struct packed {
    logic signed [W-1:0] b;
    logic signed [W-1:0] e;
    logic signed [W-1:0] den_a;
    logic signed [W-1:0] den_b;
    logic                reach;
  } dly_t;

  // stage 1: products
  logic signed [W-1:0] xs, ys, l1s, l2s, l3s, l4s, dx_c;
  always_comb begin
    xs   = W'(x);
    ys   = W'(y);
    l1s  = W'({1'b0, lk.l1});
    l2s  = W'({1'b0, lk.l2});
    l3s  = W'({1'b0, lk.l3});
    l4s  = W'({1'b0, lk.l4});
    dx_c = xs - W'({1'b0, lk.l5});
  end

  logic signed [W-1:0] a1_r, b1_r, d1_r, e1_r, xx_r, yy_r, dxx_r;
  logic signed [W-1:0] l1q_r, l2q_r, l3q_r, l4q_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r  <= (xs * l1s) <<< 1;
      b1_r  <= (ys * l1s) <<< 1;
      d1_r  <= (dx_c * l4s) <<< 1;
      e1_r  <= (ys * l4s) <<< 1;
      xx_r  <= xs * xs;
      yy_r  <= ys * ys;
      dxx_r <= dx_c * dx_c;
      l1q_r <= l1s * l1s;
      l2q_r <= l2s * l2s;
      l3q_r <= l3s * l3s;
      l4q_r <= l4s * l4s;
    end
  end

  // stage 2: c and f
  logic signed [W-1:0] a2_r, b2_r, c2_r, d2_r, e2_r, f2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a2_r <= a1_r;
      b2_r <= b1_r;
      d2_r <= d1_r;
      e2_r <= e1_r;
      c2_r <= xx_r + yy_r + l1q_r - l2q_r;
      f2_r <= dxx_r + yy_r + l4q_r - l3q_r;
    end
  end

  // stage 3: squares, atan denominators
  logic signed [DW-1:0] aa_r, bb_r, cc_r, dd_r, ee_r, ff_r;
  logic signed [W-1:0]  b3_r, e3_r, dna3_r, dnb3_r;
  always_ff @(posedge clk) begin
    if (en) begin
      aa_r   <= DW'(sq(a2_r));
      bb_r   <= DW'(sq(b2_r));
      cc_r   <= DW'(sq(c2_r));
      dd_r   <= DW'(sq(d2_r));
      ee_r   <= DW'(sq(e2_r));
      ff_r   <= DW'(sq(f2_r));
      b3_r   <= b2_r;
      e3_r   <= e2_r;
      dna3_r <= a2_r + c2_r;
      dnb3_r <= d2_r + f2_r;
    end
  end

  // stage 4: discriminants
  logic signed [DW-1:0] da_r, db_r;
  logic signed [W-1:0]  b4_r, e4_r, dna4_r, dnb4_r;
  always_ff @(posedge clk) begin
    if (en) begin
      da_r   <= aa_r + bb_r - cc_r;
      db_r   <= dd_r + ee_r - ff_r;
      b4_r   <= b3_r;
      e4_r   <= e3_r;
      dna4_r <= dna3_r;
      dnb4_r <= dnb3_r;
    end
  end

  // stage 5: clamp negatives, reachability
  logic [DW-1:0] va_r, vb_r;
  dly_t          s5_r;
  always_ff @(posedge clk) begin
    if (en) begin
      va_r <= (da_r > 0) ? DW'(da_r) : '0;
      vb_r <= (db_r > 0) ? DW'(db_r) : '0;
      s5_r <= '{b: b4_r, e: e4_r, den_a: dna4_r, den_b: dnb4_r,
                reach: (da_r >= -fbik_pkg::DISC_TOL) && (db_r >= -fbik_pkg::DISC_TOL)};
    end
  end

  logic [fbik_pkg::ROOT_W-1:0] sa, sb;
  fbik_sqrt u_sqrt_a (.clk(clk), .en(en), .val(va_r), .root(sa));
  fbik_sqrt u_sqrt_b (.clk(clk), .en(en), .val(vb_r), .root(sb));

  dly_t dl_r [0:SQ-1];
  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= s5_r;
      for (int k = 1; k < SQ; k++) dl_r[k] <= dl_r[k-1];
    end
  end

  // stage 6: numerators
  logic signed [fbik_pkg::NUM_W-1:0] na1_r, na2_r, nb1_r, nb2_r, dna_r, dnb_r;
  logic [CL:0] rch_r;
  dly_t        dq;
  assign dq = dl_r[SQ-1];
  always_ff @(posedge clk) begin
    if (en) begin
      na1_r <= dq.b + W'(sa);
      na2_r <= dq.b - W'(sa);
      nb1_r <= dq.e + W'(sb);
      nb2_r <= dq.e - W'(sb);
      dna_r <= dq.den_a;
      dnb_r <= dq.den_b;
      rch_r <= {rch_r[CL-1:0], dq.reach};
    end
  end

  logic signed [fbik_pkg::ANG_W-1:0] aa1, aa2, bt1, bt2;
  fbik_cordic u_alpha1 (.clk(clk), .en(en), .num(na1_r), .den(dna_r), .ang(aa1));
  fbik_cordic u_alpha2 (.clk(clk), .en(en), .num(na2_r), .den(dna_r), .ang(aa2));
  fbik_cordic u_beta1  (.clk(clk), .en(en), .num(nb1_r), .den(dnb_r), .ang(bt1));
  fbik_cordic u_beta2  (.clk(clk), .en(en), .num(nb2_r), .den(dnb_r), .ang(bt2));

  // stage 7: wrap alpha, pick branches
  logic signed [SW-1:0] a1w, a2w, b1e, alpha_sel_r, beta_sel_r;
  logic                 reach7_r;
  always_comb begin
    a1w = (aa1 < 0) ? SW'(aa1) + (fbik_pkg::PI_Z <<< 1) : SW'(aa1);
    a2w = (aa2 < 0) ? SW'(aa2) + (fbik_pkg::PI_Z <<< 1) : SW'(aa2);
    b1e = SW'(bt1);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      alpha_sel_r <= (a1w >= fbik_pkg::QUARTER_PI_Z) ? a1w : a2w;
      beta_sel_r  <= (b1e >= 0 && b1e <= fbik_pkg::QUARTER_PI_Z) ? b1e : SW'(bt2);
      reach7_r    <= rch_r[CL];
    end
  end

  // stage 8: minus pi/2, round half up, saturate
  logic signed [SW-1:0] am, bm;
  assign am = (alpha_sel_r + MOTOR_OFS) >>> RND_SH;
  assign bm = (beta_sel_r + MOTOR_OFS) >>> RND_SH;

  logic signed [fbik_pkg::OUT_W-1:0] alpha_r, beta_r;
  logic                              reach_r;
  always_ff @(posedge clk) begin
    if (en) begin
      alpha_r <= (am > SAT_HI) ? fbik_pkg::OUT_W'(SAT_HI) :
                 (am < SAT_LO) ? fbik_pkg::OUT_W'(SAT_LO) : fbik_pkg::OUT_W'(am);
      beta_r  <= (bm > SAT_HI) ? fbik_pkg::OUT_W'(SAT_HI) :
                 (bm < SAT_LO) ? fbik_pkg::OUT_W'(SAT_LO) : fbik_pkg::OUT_W'(bm);
      reach_r <= reach7_r;
    end
  end

  assign alpha = alpha_r;
  assign beta  = beta_r;
  assign reach = reach_r;

endmodule

@@ sv/five_bar_leg_inverse_kinematics.sv @@
// Top level of the five-bar leg IK block: config registers, two leg lanes,
// merge into a two-entry output skid. Depends on fbik_pkg and fbik_leg.
//
// Takes one pose (left and right foot targets) per clock and returns, for each
// leg, the two motor angles (minus pi/2, 1/4096 rad, saturated to 16 bits) and a
// reachability flag. The pipeline runs the polynomial terms (products, c and f,
// squares, discriminants, clamp), a 30-stage square root (one root bit per
// stage), a numerator stage, an atan unit (sign fold, 6 normalize shifts, 30
// rotator steps, special cases), a branch pick stage and a scaling stage.
// Both legs run in parallel lanes, each with two roots and four atan units.
// The whole pipeline advances together; it holds only when both skid entries
// are full, so in_tready never depends on out_tready in the same cycle and a
// new pose is taken while one result waits. Sustained rate: one pose per cycle.
// Link lengths are to be written through the cfg port only while the block is
// idle, which the user must ensure; cfg_ready is always high, unused indexes drop.
module five_bar_leg_inverse_kinematics (
  input  logic                                clk,
  input  logic                                rst_n,
  // left_x[13:0], left_y[27:14], right_x[41:28], right_y[55:42]
  input  logic [fbik_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // left_alpha_motor[15:0], left_beta_motor[31:16], right_alpha_motor[47:32],
  // right_beta_motor[63:48], left_reachable[64], right_reachable[65]
  output logic [fbik_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [fbik_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbik_pkg::LEN_W-1:0]          cfg_data
);

  localparam int IW  = fbik_pkg::IN_W;
  localparam int OW  = fbik_pkg::OUT_W;
  localparam int LAT = fbik_pkg::LEG_LAT;

  // ---- configuration registers ----
  fbik_pkg::links_t lk_r, lk_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    lk_nxt = lk_r;
    if (cfg_valid) begin
      case (fbik_pkg::cfg_reg_e'(cfg_index))
        fbik_pkg::REG_LINK_ONE:   lk_nxt.l1 = cfg_data;
        fbik_pkg::REG_LINK_TWO:   lk_nxt.l2 = cfg_data;
        fbik_pkg::REG_LINK_THREE: lk_nxt.l3 = cfg_data;
        fbik_pkg::REG_LINK_FOUR:  lk_nxt.l4 = cfg_data;
        fbik_pkg::REG_HIP:        lk_nxt.l5 = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_r <= '{fbik_pkg::LEN_RESET, fbik_pkg::LEN_RESET, fbik_pkg::LEN_RESET,
                fbik_pkg::LEN_RESET, fbik_pkg::LEN_RESET};
    end else begin
      lk_r <= lk_nxt;
    end
  end

  // ---- pipeline advance: stall only when both skid slots are taken ----
  logic [1:0] cnt_r, cnt_nxt;
  logic       adv;
  assign adv       = (cnt_r != 2'd2);
  assign in_tready = adv;

  logic [LAT-1:0] vld_r, vld_nxt;
  assign vld_nxt = adv ? {vld_r[LAT-2:0], in_tvalid} : vld_r;

  // ---- leg lanes ----
  logic signed [OW-1:0] la, lb, ra, rb;
  logic                 lr, rr;

  fbik_leg u_left (
    .clk(clk), .en(adv), .lk(lk_r),
    .x(signed'(in_tdata[IW-1:0])), .y(signed'(in_tdata[2*IW-1:IW])),
    .alpha(la), .beta(lb), .reach(lr)
  );

  fbik_leg u_right (
    .clk(clk), .en(adv), .lk(lk_r),
    .x(signed'(in_tdata[3*IW-1:2*IW])), .y(signed'(in_tdata[4*IW-1:3*IW])),
    .alpha(ra), .beta(rb), .reach(rr)
  );

  // ---- merge and output skid ----
  logic [fbik_pkg::OUT_TDATA_W-1:0] merged;
  assign merged = {6'b0, rr, lr, rb, ra, lb, la};

  logic [fbik_pkg::OUT_TDATA_W-1:0] skid_r [0:1];
  logic wp_r, wp_nxt, rp_r, rp_nxt;
  logic push, pop;

  assign push = adv && vld_r[LAT-1];
  assign pop  = out_tvalid && out_tready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
      cnt_r <= cnt_nxt;
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      skid_r[wp_r] <= merged;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = skid_r[rp_r];

endmodule

@@ sv/fbik_checker.sv @@
// Port-level checks for the five-bar leg IK top level, bound to it below.
// Depends on five_bar_leg_inverse_kinematics and fbik_pkg.
module fbik_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic [fbik_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [fbik_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic                             cfg_valid,
  input logic                             cfg_ready,
  input logic [fbik_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [fbik_pkg::LEN_W-1:0]       cfg_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // nothing pending right after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input stalls only behind a waiting result
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output");

  // skid fills only when a result was refused
  a_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

endmodule

bind five_bar_leg_inverse_kinematics fbik_checker u_fbik_checker (.*);

@@ test/testbench.sv @@
// Self-checking bench for the five-bar leg IK block: directed poses, then random
// poses under several link settings, compared against a behavioral predictor.
// Depends on fbik_pkg and five_bar_leg_inverse_kinematics.
module testbench;

  localparam int N_RANDOM    = 1150;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = fbik_pkg::LEG_LAT + 20;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic [fbik_pkg::IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [fbik_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [fbik_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fbik_pkg::LEN_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  five_bar_leg_inverse_kinematics u_top (.*);

  typedef struct packed {
    logic signed [15:0] la, lb, ra, rb;
    logic lr, rr;
  } pose_cmd_t;

  // link lengths as the predictor sees them
  logic [fbik_pkg::LEN_W-1:0] len_l1, len_l2, len_l3, len_l4, len_hip;

  pose_cmd_t cmd_queue[$];
  int errors = 0;
  int poses_sent = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit rx_no_idle = 0;
  bit rx_hold = 0;
  bit tx_no_idle = 0;

  // ---------------- predictor ----------------
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;  // arithmetic on signed longint rounds toward -inf
  endfunction

  function automatic longint int_root(longint v);
    longint unsigned r = 0, b = 64'd1 << 62, x = v;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint rot_step(int i);
    longint t[10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                      16771758, 8387925, 4194219, 2097141, 1048575};
    if (i < 10) return t[i];
    return 64'sd1 <<< (29 - i);
  endfunction

  // 2*atan(num/den), Q29 radians
  function automatic longint double_atan(longint num, longint den);
    longint x, y, z, xs, ys;
    longint unsigned m;
    z = 0;
    if (num == 0) return 0;
    if (den == 0) return num > 0 ? 64'sd1686629712 : -64'sd1686629712;
    x = den < 0 ? -den : den;
    y = den < 0 ? -num : num;
    m = y < 0 ? -y : y;
    if (longint'(x) > longint'(m)) m = x;
    while (m < (64'd1 << 32)) begin
      m <<= 1; x *= 2; y *= 2;
    end
    for (int i = 0; i < 30; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += rot_step(i);
      end else begin
        x -= ys; y += xs; z -= rot_step(i);
      end
    end
    return 2 * z;
  endfunction

  function automatic logic signed [15:0] motor_cmd(longint ang);
    longint r;
    r = shr_floor(ang - 843314856 + (64'sd1 <<< 16), 17);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  function automatic void solve_leg(input longint x, input longint y,
                                    output logic signed [15:0] alpha_m,
                                    output logic signed [15:0] beta_m,
                                    output logic reach);
    longint l1, l2, l3, l4, l5, dx, a, b, c, d, e, f, da, db, sa, sb;
    longint a1, a2, b1, b2, al, be;
    l1 = len_l1; l2 = len_l2; l3 = len_l3; l4 = len_l4; l5 = len_hip;
    dx = x - l5;
    a = 2 * x * l1; b = 2 * y * l1;
    c = x * x + y * y + l1 * l1 - l2 * l2;
    d = 2 * l4 * dx; e = 2 * l4 * y;
    f = dx * dx + l4 * l4 + y * y - l3 * l3;
    da = a * a + b * b - c * c;
    db = d * d + e * e - f * f;
    sa = da > 0 ? int_root(da) : 0;
    sb = db > 0 ? int_root(db) : 0;
    a1 = double_atan(b + sa, a + c);
    a2 = double_atan(b - sa, a + c);
    b1 = double_atan(e + sb, d + f);
    b2 = double_atan(e - sb, d + f);
    if (a1 < 0) a1 += 2 * 64'sd1686629713;
    if (a2 < 0) a2 += 2 * 64'sd1686629713;
    al = a1 >= 421657428 ? a1 : a2;
    be = (b1 >= 0 && b1 <= 421657428) ? b1 : b2;
    alpha_m = motor_cmd(al);
    beta_m = motor_cmd(be);
    reach = (da >= -65 && db >= -65);
  endfunction

  function automatic pose_cmd_t predict_pose(logic [fbik_pkg::IN_TDATA_W-1:0] p);
    pose_cmd_t r;
    solve_leg(longint'($signed(p[13:0])), longint'($signed(p[27:14])),
              r.la, r.lb, r.lr);
    solve_leg(longint'($signed(p[41:28])), longint'($signed(p[55:42])),
              r.ra, r.rb, r.rr);
    return r;
  endfunction

  // ---------------- result checker ----------------
  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    pose_cmd_t e;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (cmd_queue.size() == 0) begin
        $error("result with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        e = cmd_queue.pop_front();
        check_field("left_alpha_motor", e.la, $signed(out_tdata[15:0]));
        check_field("left_beta_motor", e.lb, $signed(out_tdata[31:16]));
        check_field("right_alpha_motor", e.ra, $signed(out_tdata[47:32]));
        check_field("right_beta_motor", e.rb, $signed(out_tdata[63:48]));
        check_field("left_reachable", e.lr, out_tdata[64]);
        check_field("right_reachable", e.rr, out_tdata[65]);
      end
    end
  end

  // watchdog: cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // receiver: random stalls, a no-stall stretch, and a long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (rx_hold) out_tready <= 1'b0;
    else if (rx_no_idle) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 35);
  end

  initial begin
    forever begin
      @(negedge clk);
      if (rx_hold) begin
        repeat (300) @(negedge clk);  // long back-pressure: pipeline fills up
        rx_hold = 0;
      end
    end
  end

  // ---------------- stimulus ----------------
  // leaves in_tvalid high on return; idle gaps and drain() drop it
  task automatic send_pose(logic [fbik_pkg::IN_TDATA_W-1:0] p, bit has_exp = 0,
                           pose_cmd_t fixed = '{default: 0});
    pose_cmd_t pr;
    if (!tx_no_idle)
      while ($urandom_range(99) < 35) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    pr = predict_pose(p);
    if (has_exp) begin
      // typed-in expectation must agree with the predictor as well
      check_field("left_alpha_motor", fixed.la, pr.la);
      check_field("left_beta_motor", fixed.lb, pr.lb);
      check_field("right_alpha_motor", fixed.ra, pr.ra);
      check_field("right_beta_motor", fixed.rb, pr.rb);
      check_field("left_reachable", fixed.lr, pr.lr);
      check_field("right_reachable", fixed.rr, pr.rr);
    end
    in_tdata <= p;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    cmd_queue.push_back(pr);
    poses_sent++;
    @(negedge clk);
  endtask

  function automatic logic [fbik_pkg::IN_TDATA_W-1:0] pack_pose(int lx, int ly,
                                                               int rx, int ry);
    return {14'(ry), 14'(rx), 14'(ly), 14'(lx)};
  endfunction

  // leaves cfg_valid high on return; set_links drops it
  task automatic write_link(fbik_pkg::cfg_reg_e idx, logic [fbik_pkg::LEN_W-1:0] v);
    cfg_index <= idx;
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      fbik_pkg::REG_LINK_ONE:   len_l1 = v;
      fbik_pkg::REG_LINK_TWO:   len_l2 = v;
      fbik_pkg::REG_LINK_THREE: len_l3 = v;
      fbik_pkg::REG_LINK_FOUR:  len_l4 = v;
      fbik_pkg::REG_HIP:        len_hip = v;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_links(int a, int b, int c, int d, int h);
    write_link(fbik_pkg::REG_LINK_ONE, fbik_pkg::LEN_W'(a));
    write_link(fbik_pkg::REG_LINK_TWO, fbik_pkg::LEN_W'(b));
    write_link(fbik_pkg::REG_LINK_THREE, fbik_pkg::LEN_W'(c));
    write_link(fbik_pkg::REG_LINK_FOUR, fbik_pkg::LEN_W'(d));
    write_link(fbik_pkg::REG_HIP, fbik_pkg::LEN_W'(h));
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (cmd_queue.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // a target in [-3200, 3200], or full-range noise over [-8192, 8191]
  function automatic int rand_coord(bit wide);
    if (wide) return $urandom_range(16383) - 8192;
    return int'($urandom_range(2 * 3200)) - 3200;
  endfunction

  typedef struct {
    int lx, ly, rx, ry;
    bit has_exp;
    pose_cmd_t exp_cmd;
  } pose_row_t;

  pose_row_t directed[$];

  initial begin
    pose_row_t row;
    logic [fbik_pkg::IN_TDATA_W-1:0] p;
    len_l1 = fbik_pkg::LEN_RESET; len_l2 = fbik_pkg::LEN_RESET;
    len_l3 = fbik_pkg::LEN_RESET; len_l4 = fbik_pkg::LEN_RESET;
    len_hip = fbik_pkg::LEN_RESET;

    // all-zero pose: every numerator is zero except the hip-side root terms
    directed.push_back('{0, 0, 0, 0, 0, '{default: 0}});
    directed.push_back('{8191, 8191, 8191, 8191, 0, '{default: 0}});
    directed.push_back('{-8192, -8192, -8192, -8192, 0, '{default: 0}});
    directed.push_back('{8191, -8192, -8192, 8191, 0, '{default: 0}});
    directed.push_back('{-1, -1, 1, 1, 0, '{default: 0}});
    // foot on the hip axis: zero denominators and zero numerators
    directed.push_back('{1600, 0, 0, 0, 0, '{default: 0}});
    directed.push_back('{800, 2771, 800, -2771, 0, '{default: 0}});
    directed.push_back('{800, 1000, 1600, 1600, 0, '{default: 0}});
    directed.push_back('{3200, 0, -1600, 0, 0, '{default: 0}});
    directed.push_back('{800, 0, 800, 3000, 0, '{default: 0}});
    directed.push_back('{5461, 5461, -5461, 2730, 0, '{default: 0}});
    directed.push_back('{0, 3200, 1600, 3200, 0, '{default: 0}});

    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset links first, then directed table
    foreach (directed[i]) begin
      row = directed[i];
      send_pose(pack_pose(row.lx, row.ly, row.rx, row.ry), row.has_exp, row.exp_cmd);
    end
    drain();

    // link extremes: all zero, then all max (saturating angles)
    set_links(0, 0, 0, 0, 0);
    send_pose(pack_pose(0, 0, 0, 0));
    send_pose(pack_pose(8191, -8192, 100, 100));
    drain();
    set_links(8191, 8191, 8191, 8191, 8191);
    send_pose(pack_pose(8191, 8191, -8192, -8192));
    send_pose(pack_pose(0, 8191, 4000, -100));
    drain();

    // random phases, each with its own link set
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_links(1600, 1600, 1600, 1600, 1600);
        1: set_links(1000, 2200, 2200, 1000, 800);
        5: set_links($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
                     $urandom_range(8191), $urandom_range(8191));
        default: set_links($urandom_range(400, 3000), $urandom_range(400, 3000),
                           $urandom_range(400, 3000), $urandom_range(400, 3000),
                           $urandom_range(0, 3000));
      endcase
      tx_no_idle = (ph == 2);
      rx_no_idle = (ph == 2);
      for (int k = 0; k < N_RANDOM / 6; k++) begin
        if (ph == 3 && k == 20) rx_hold = 1;
        // mostly targets near the working area, some full-range noise
        p = pack_pose(rand_coord($urandom_range(9) == 0), rand_coord($urandom_range(9) == 0),
                      rand_coord($urandom_range(9) == 0), rand_coord($urandom_range(9) == 0));
        if ($urandom_range(19) == 0) p = fbik_pkg::IN_TDATA_W'({$urandom, $urandom});
        send_pose(p);
      end
      tx_no_idle = 0;
      rx_no_idle = 0;
      drain();
    end

    $display("covered %0d poses, %0d results, link settings incl. zero and max",
             poses_sent, results_seen);
    if (errors == 0 && cmd_queue.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
